### sv/zs_pkg.sv
// ----------------------------------------------------------------------------
// zs_pkg
// Shared types and constants of the Zipf sampler: field widths, opcodes,
// generator constants, the command that travels from front to back, and the
// back-end state machine.
// ----------------------------------------------------------------------------
`default_nettype none

package zs_pkg;

   localparam int ZS_MAX_ITEMS = 4096;

   localparam int IDX_W    = 13;
   localparam int THR_W    = 31;
   localparam int SAMPLE_W = 12;
   localparam int COUNT_W  = 13;

   localparam int REQ_DATA_W = 48;
   localparam int RSP_DATA_W = 16;

   localparam int CMD_QUEUE_DEPTH = 4;

   localparam logic [COUNT_W-1:0] ITEM_COUNT_RESET = 13'd4096;

   localparam logic [14:0] LCG_MULT = 15'd16807;
   localparam logic [31:0] LCG_MOD  = 32'h7FFF_FFFF;
   localparam logic [30:0] LCG_SEED = 31'd1687248;

   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_DRAW = 1'b1;

   typedef struct packed {
      logic             opcode;
      logic [IDX_W-1:0] entry_index;
      logic [THR_W-1:0] threshold;
   } cmd_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MULT,
      ST_REDUCE,
      ST_SEARCH,
      ST_OUTPUT
   } back_state_type;

endpackage

`default_nettype wire

### sv/zs_front.sv
// ----------------------------------------------------------------------------
// zs_front
// Request front end: takes items from the stream, drops loads whose position
// lies outside the table and registers the rest as commands for the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module zs_front
   import zs_pkg::*;
#(
   parameter int MAX_ITEMS = ZS_MAX_ITEMS
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   input  wire logic                  req_tuser,
   output logic                       cmd_valid,
   input  wire logic                  cmd_ready,
   output cmd_type                    cmd
);

   logic    valid_ff, valid_in;
   cmd_type cmd_ff, cmd_in;
   cmd_type decoded;
   logic    accept;
   logic    keep;
   logic [31:0] idx32;

   assign req_tready = !valid_ff || cmd_ready;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      decoded.opcode      = req_tuser;
      decoded.entry_index = req_tdata[IDX_W-1:0];
      decoded.threshold   = req_tdata[IDX_W+THR_W-1:IDX_W];
      idx32 = 32'(decoded.entry_index);
      // loads to position zero or past the table end have no effect
      keep = (decoded.opcode == OP_DRAW) ||
             ((idx32 != 32'd0) && (idx32 <= 32'(MAX_ITEMS)));
   end

   always_comb begin
      valid_in = valid_ff;
      cmd_in   = cmd_ff;
      if (valid_ff && cmd_ready) begin
         valid_in = 1'b0;
      end
      if (accept) begin
         valid_in = keep;
         cmd_in   = decoded;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      cmd_ff <= cmd_in;
   end

   assign cmd_valid = valid_ff;
   assign cmd       = cmd_ff;

endmodule

`default_nettype wire

### sv/zs_cmd_fifo.sv
// ----------------------------------------------------------------------------
// zs_cmd_fifo
// Short command queue between front end and back end.
// ----------------------------------------------------------------------------
`default_nettype none

module zs_cmd_fifo
   import zs_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push_valid,
   output logic         push_ready,
   input  wire cmd_type push_cmd,
   output logic         pop_valid,
   input  wire logic    pop_ready,
   output cmd_type      pop_cmd
);

   localparam int PTR_W = $clog2(CMD_QUEUE_DEPTH);
   localparam int CNT_W = $clog2(CMD_QUEUE_DEPTH + 1);

   cmd_type entries_ff [CMD_QUEUE_DEPTH];

   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign push_ready = (count_ff != CNT_W'(CMD_QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_cmd    = entries_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(CMD_QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(CMD_QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

`default_nettype wire

### sv/zs_back.sv
// ----------------------------------------------------------------------------
// zs_back
// Back end: owns the threshold table and the generator. Loads write the
// table; a draw steps the generator and binary-searches the table, one
// probe per cycle with two read ports, then hands the sample to the output
// register.
// ----------------------------------------------------------------------------
`default_nettype none

module zs_back
   import zs_pkg::*;
#(
   parameter int MAX_ITEMS = ZS_MAX_ITEMS
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic [COUNT_W-1:0]  item_count,
   input  wire logic                cmd_valid,
   output logic                     cmd_ready,
   input  wire cmd_type             cmd,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output logic [SAMPLE_W-1:0]      rsp_sample
);

   localparam int AW = $clog2(MAX_ITEMS);
   localparam int LW = $clog2(MAX_ITEMS + 2);

   back_state_type state_ff, state_in;

   logic [THR_W-1:0]    gen_ff, gen_in;
   logic [45:0]         prod_ff, prod_in;
   logic [LW-1:0]       low_ff, low_in;
   logic [LW-1:0]       high_ff, high_in;
   logic [LW-1:0]       mid_ff, mid_in;
   logic                prev_zero_ff, prev_zero_in;
   logic [LW-1:0]       res_ff, res_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [SAMPLE_W-1:0] rsp_sample_ff, rsp_sample_in;

   logic [THR_W-1:0] table_mem [MAX_ITEMS];
   logic [THR_W-1:0] rd_a_ff, rd_b_ff;
   logic [AW-1:0]    rd_addr_a, rd_addr_b;
   logic             wr_en;
   logic [AW-1:0]    wr_addr;
   logic [31:0]      wr_pos32;

   logic [31:0]   cnt32;
   logic [LW-1:0] n_eff;
   logic [LW-1:0] n_last;
   logic [31:0]   red_sum;
   logic [31:0]   red_mod;
   logic [LW-1:0] next_mid;
   logic [LW-1:0] mid_dec, mid_inc;
   logic [LW-1:0] addr_a_pos, addr_b_pos;
   logic [LW:0]   sum_first, sum_lower, sum_upper;
   logic [THR_W-1:0] t_mid, t_prev;
   logic          at_or_above, match;
   logic [31:0]   res32;

   // count zero acts as one, counts past the table as the table size
   always_comb begin
      cnt32 = 32'(item_count);
      if (cnt32 == 32'd0) begin
         n_eff = LW'(1);
      end else if (cnt32 > 32'(MAX_ITEMS)) begin
         n_eff = LW'(MAX_ITEMS);
      end else begin
         n_eff = cnt32[LW-1:0];
      end
      n_last = n_eff - LW'(1);
   end

   // mod 2^31-1 folds the high bits back onto the low ones
   assign red_sum = {1'b0, prod_ff[30:0]} + {17'd0, prod_ff[45:31]};
   assign red_mod = (red_sum >= LCG_MOD) ? red_sum - LCG_MOD : red_sum;

   assign wr_pos32 = 32'(cmd.entry_index) - 32'd1;
   assign wr_addr  = wr_pos32[AW-1:0];

   assign mid_dec   = mid_ff - LW'(1);
   assign mid_inc   = mid_ff + LW'(1);
   assign sum_first = (LW+1)'(1) + {1'b0, n_eff};
   assign sum_lower = {1'b0, low_ff} + {1'b0, mid_dec};
   assign sum_upper = {1'b0, mid_inc} + {1'b0, high_ff};

   assign t_mid       = rd_a_ff;
   assign t_prev      = prev_zero_ff ? '0 : rd_b_ff;
   assign at_or_above = (t_mid >= gen_ff);
   assign match       = at_or_above && (t_prev < gen_ff);

   assign res32 = 32'(res_ff);

   always_comb begin
      state_in      = state_ff;
      gen_in        = gen_ff;
      prod_in       = prod_ff;
      low_in        = low_ff;
      high_in       = high_ff;
      mid_in        = mid_ff;
      prev_zero_in  = prev_zero_ff;
      res_in        = res_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_sample_in = rsp_sample_ff;
      next_mid      = mid_ff;
      cmd_ready     = 1'b0;
      wr_en         = 1'b0;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            cmd_ready = 1'b1;
            if (cmd_valid) begin
               if (cmd.opcode == OP_DRAW) begin
                  state_in = ST_MULT;
               end else begin
                  wr_en = 1'b1;
               end
            end
         end
         ST_MULT: begin
            prod_in  = 46'(gen_ff) * 46'(LCG_MULT);
            state_in = ST_REDUCE;
         end
         ST_REDUCE: begin
            gen_in   = red_mod[THR_W-1:0];
            low_in   = LW'(1);
            high_in  = n_eff;
            next_mid = sum_first[LW:1];
            mid_in   = next_mid;
            prev_zero_in = (next_mid == LW'(1));
            state_in = ST_SEARCH;
         end
         ST_SEARCH: begin
            if (match) begin
               res_in   = mid_dec;
               state_in = ST_OUTPUT;
            end else if (at_or_above) begin
               high_in = mid_dec;
               if (low_ff > mid_dec) begin
                  res_in   = n_last;
                  state_in = ST_OUTPUT;
               end else begin
                  next_mid     = sum_lower[LW:1];
                  mid_in       = next_mid;
                  prev_zero_in = (next_mid == LW'(1));
               end
            end else begin
               low_in = mid_inc;
               if (mid_inc > high_ff) begin
                  res_in   = n_last;
                  state_in = ST_OUTPUT;
               end else begin
                  next_mid     = sum_upper[LW:1];
                  mid_in       = next_mid;
                  prev_zero_in = (next_mid == LW'(1));
               end
            end
         end
         ST_OUTPUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_sample_in = res32[SAMPLE_W-1:0];
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // position p lives at address p-1; the lower neighbor at p-2
      addr_a_pos = next_mid - LW'(1);
      addr_b_pos = next_mid - LW'(2);
      rd_addr_a  = addr_a_pos[AW-1:0];
      rd_addr_b  = addr_b_pos[AW-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         gen_ff       <= LCG_SEED;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         gen_ff       <= gen_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      prod_ff       <= prod_in;
      low_ff        <= low_in;
      high_ff       <= high_in;
      mid_ff        <= mid_in;
      prev_zero_ff  <= prev_zero_in;
      res_ff        <= res_in;
      rsp_sample_ff <= rsp_sample_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         table_mem[wr_addr] <= cmd.threshold;
      end
      rd_a_ff <= table_mem[rd_addr_a];
      rd_b_ff <= table_mem[rd_addr_b];
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_sample = rsp_sample_ff;

endmodule

`default_nettype wire

### sv/zipf_sampler_top.sv
// ----------------------------------------------------------------------------
// zipf_sampler_top
// Zipf sample generator: loads a cumulative threshold table and answers each
// draw with the index found by binary search for a Park-Miller random value.
//
//   channel  dir  handshake              payload
//   req_     in   req_tvalid/req_tready  tuser: opcode; tdata: entry_index,
//                                        threshold
//   rsp_     out  rsp_tvalid/rsp_tready  tdata: sample
//   csr_     in   csr_valid/csr_ready    csr_data: item_count
//
// A load is written while the back end is idle. A draw steps through accept,
// multiply, fold, the search probes and output; the search makes one probe
// per cycle over the table's two read ports, at most ceil(log2(n+1)) probes,
// n being item_count with zero as one and counts past the table capped at
// the table size (13 for 4096). An accepted item passes the front register
// and the queue before the back end takes it; the queue lets new items enter
// while a draw searches or its sample waits on rsp_tready.
// Reset is synchronous; the table holds no reset value and needs no sweep.
// ----------------------------------------------------------------------------
`default_nettype none

module zipf_sampler_top
   import zs_pkg::*;
#(
   parameter int MAX_ITEMS = ZS_MAX_ITEMS
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   // [12:0] entry_index, [43:13] threshold, [47:44] zero
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   // [0] opcode
   input  wire logic                  req_tuser,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   // [11:0] sample, [15:12] zero
   output logic [RSP_DATA_W-1:0]      rsp_tdata,
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic [COUNT_W-1:0]    csr_data
);

   logic [COUNT_W-1:0] item_count_ff, item_count_in;

   logic    front_valid, front_ready;
   cmd_type front_cmd;
   logic    back_valid, back_ready;
   cmd_type back_cmd;
   logic [SAMPLE_W-1:0] sample;

   assign csr_ready = 1'b1;

   always_comb begin
      item_count_in = item_count_ff;
      if (csr_valid && csr_ready) begin
         item_count_in = csr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_count_ff <= ITEM_COUNT_RESET;
      end else begin
         item_count_ff <= item_count_in;
      end
   end

   zs_front #(
      .MAX_ITEMS (MAX_ITEMS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .cmd_valid  (front_valid),
      .cmd_ready  (front_ready),
      .cmd        (front_cmd)
   );

   zs_cmd_fifo u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (front_valid),
      .push_ready (front_ready),
      .push_cmd   (front_cmd),
      .pop_valid  (back_valid),
      .pop_ready  (back_ready),
      .pop_cmd    (back_cmd)
   );

   zs_back #(
      .MAX_ITEMS (MAX_ITEMS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .item_count (item_count_ff),
      .cmd_valid  (back_valid),
      .cmd_ready  (back_ready),
      .cmd        (back_cmd),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp_sample (sample)
   );

   assign rsp_tdata = {{(RSP_DATA_W-SAMPLE_W){1'b0}}, sample};

endmodule

`default_nettype wire

### bench/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the Zipf sampler. Loads cumulative threshold
// tables, sets the value count and issues draws; entries that a draw's search
// will reach are loaded ahead of it. A local Park-Miller generator and a
// midpoint search over a shadow table give the sample that is expected for
// each draw. Both sides of the stream insert random gaps, and the result side
// holds off once for a long stretch so that the input backs up.
// ----------------------------------------------------------------------------

module tb_top;
   import zs_pkg::*;

   localparam int SETTLE_CYCLES  = 64;
   localparam int LONG_HOLD      = 400;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int TOTAL_ITEMS    = 450;
   localparam logic [THR_W-1:0] THR_MAX = '1;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic                  req_tuser  = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_valid  = 1'b0;
   logic                  csr_ready;
   logic [COUNT_W-1:0]    csr_data   = '0;

   // draw-side state, updated as items are accepted
   logic [THR_W-1:0]    thresholds [1:ZS_MAX_ITEMS];
   logic [THR_W-1:0]    generator_value = LCG_SEED;
   int                  search_count    = ZS_MAX_ITEMS;
   logic [SAMPLE_W-1:0] expected_samples [$];

   // table contents as planned by the stimulus, index 0 is a fixed zero
   logic [THR_W-1:0] staged_table [0:ZS_MAX_ITEMS];
   bit               staged_written [0:ZS_MAX_ITEMS];
   logic [THR_W-1:0] plan_value = LCG_SEED;
   cmd_type          pending_items [$];
   cmd_type          active_item;
   int               queued_items = 0;

   int idle_mode         = 1;
   int long_holds_asked  = 0;
   int long_holds_done   = 0;
   int req_gap_left      = 0;
   int rsp_hold_left     = 0;
   int mismatches        = 0;
   int quiet_cycles      = 0;

   zipf_sampler_top i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic int idle_gap();
      int r;
      r = $urandom_range(0, 99);
      if (idle_mode == 0 || r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [THR_W-1:0] lcg_step(logic [THR_W-1:0] x);
      logic [63:0] product;
      product = 64'(LCG_MULT) * 64'(x);
      return THR_W'(product % 64'(LCG_MOD));
   endfunction

   // midpoint search for the first position whose threshold reaches x
   function automatic logic [SAMPLE_W-1:0] zipf_search(logic [THR_W-1:0] x, int n);
      int               lo;
      int               hi;
      int               mid;
      bit               found;
      logic [THR_W-1:0] below;
      logic [SAMPLE_W-1:0] pick;
      pick  = SAMPLE_W'(n - 1);
      lo    = 1;
      hi    = n;
      found = 1'b0;
      while (lo <= hi && !found) begin
         mid   = (lo + hi) / 2;
         below = (mid == 1) ? '0 : thresholds[mid - 1];
         if (thresholds[mid] >= x) begin
            if (below < x) begin
               pick  = SAMPLE_W'(mid - 1);
               found = 1'b1;
            end else begin
               hi = mid - 1;
            end
         end else begin
            lo = mid + 1;
         end
      end
      return pick;
   endfunction

   always @(posedge clock) begin : req_side
      if (reset) begin
         req_tvalid <= 1'b0;
         req_gap_left = 0;
      end else begin
         if (req_tvalid && req_tready) begin
            if (active_item.opcode == OP_DRAW) begin
               generator_value = lcg_step(generator_value);
               expected_samples = {expected_samples,
                                   zipf_search(generator_value, search_count)};
            end else if (active_item.entry_index >= 1 &&
                         active_item.entry_index <= ZS_MAX_ITEMS) begin
               thresholds[active_item.entry_index] = active_item.threshold;
            end
         end
         if (!req_tvalid || req_tready) begin
            if (req_gap_left > 0 || pending_items.size() == 0) begin
               if (req_gap_left > 0) req_gap_left--;
               req_tvalid <= 1'b0;
            end else begin
               active_item = pending_items.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= REQ_DATA_W'({active_item.threshold, active_item.entry_index});
               req_tuser  <= active_item.opcode;
               req_gap_left = idle_gap();
            end
         end
      end
   end

   always @(posedge clock) begin : rsp_side
      logic [SAMPLE_W-1:0] wanted;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_samples.size() == 0) begin
               $display("%0t: sample mismatch, expected none, actual %0d",
                        $time, rsp_tdata[SAMPLE_W-1:0]);
               mismatches++;
            end else begin
               wanted = expected_samples.pop_front();
               if (rsp_tdata[SAMPLE_W-1:0] !== wanted) begin
                  $display("%0t: sample mismatch, expected %0d, actual %0d",
                           $time, wanted, rsp_tdata[SAMPLE_W-1:0]);
                  mismatches++;
               end
            end
         end
         if (long_holds_done < long_holds_asked) begin
            long_holds_done++;
            rsp_hold_left = LONG_HOLD;
         end
         if (rsp_hold_left > 0) begin
            rsp_hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            rsp_hold_left = idle_gap();
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == WATCHDOG_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic queue_item(logic op, logic [IDX_W-1:0] idx, logic [THR_W-1:0] thr);
      cmd_type c;
      c.opcode      = op;
      c.entry_index = idx;
      c.threshold   = thr;
      pending_items = {pending_items, c};
      queued_items++;
      if (op == OP_LOAD && idx >= 1 && idx <= ZS_MAX_ITEMS) begin
         staged_table[idx]   = thr;
         staged_written[idx] = 1'b1;
      end
   endtask

   // give a never-written entry a value between its written neighbors, most
   // of the time on the side of x that ends the search there
   task automatic fill_entry(int pos, logic [THR_W-1:0] x, bit want_above);
      int               k;
      logic [THR_W-1:0] lb;
      logic [THR_W-1:0] ub;
      logic [THR_W-1:0] val;
      k = pos - 1;
      while (k > 0 && !staged_written[k]) k--;
      lb = staged_table[k];
      k = pos + 1;
      while (k <= ZS_MAX_ITEMS && !staged_written[k]) k++;
      ub = (k > ZS_MAX_ITEMS) ? THR_MAX : staged_table[k];
      if (ub < lb) ub = THR_MAX;
      if ($urandom_range(0, 3) != 0) begin
         if (want_above && x <= ub) begin
            if (x > lb) lb = x;
         end else if (!want_above && x > lb) begin
            if (x - 1 < ub) ub = x - 1;
         end
      end
      val = THR_W'(lb + $urandom_range(0, ub - lb));
      queue_item(OP_LOAD, IDX_W'(pos), val);
   endtask

   // draw fields carry random content, the block must ignore it; every entry
   // that this draw's search reads is loaded before the draw
   task automatic queue_draw();
      int lo;
      int hi;
      int mid;
      bit found;
      plan_value = lcg_step(plan_value);
      lo    = 1;
      hi    = search_count;
      found = 1'b0;
      while (lo <= hi && !found) begin
         mid = (lo + hi) / 2;
         if (!staged_written[mid]) fill_entry(mid, plan_value, 1'b1);
         if (staged_table[mid] >= plan_value) begin
            if (mid > 1 && !staged_written[mid - 1]) fill_entry(mid - 1, plan_value, 1'b0);
            if (staged_table[mid - 1] < plan_value) found = 1'b1;
            else hi = mid - 1;
         end else begin
            lo = mid + 1;
         end
      end
      queue_item(OP_DRAW, IDX_W'($urandom), THR_W'($urandom));
   endtask

   // wait for the input side to empty and every sample to arrive
   task automatic settle_block();
      do @(negedge clock);
      while (pending_items.size() != 0 || req_tvalid || expected_samples.size() != 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_item_count(logic [COUNT_W-1:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock);
      while (!csr_ready);
      csr_valid <= 1'b0;
      // zero counts as one, anything past the table as the full table
      if (value == 0) search_count = 1;
      else if (value > ZS_MAX_ITEMS) search_count = ZS_MAX_ITEMS;
      else search_count = value;
      @(negedge clock);
   endtask

   // ascending cdf over positions 1..n, usually topped at full scale
   task automatic load_cdf(int n);
      longint prev;
      longint span;
      longint val;
      int     k;
      prev = 0;
      for (k = 1; k <= n; k++) begin
         span = (longint'(THR_MAX) - prev) / (n - k + 1);
         val  = prev + longint'($urandom_range(0, 32'(2 * span)));
         if (val > longint'(THR_MAX)) val = THR_MAX;
         if (k == n && $urandom_range(0, 4) != 0) val = THR_MAX;
         queue_item(OP_LOAD, IDX_W'(k), THR_W'(val));
         prev = val;
      end
   endtask

   // rewrite one entry between its neighbors so the table stays ordered
   task automatic patch_entry(int n);
      int               idx;
      logic [THR_W-1:0] lo;
      logic [THR_W-1:0] hi;
      logic [THR_W-1:0] val;
      idx = $urandom_range(1, n);
      lo  = staged_table[idx - 1];
      hi  = (idx == ZS_MAX_ITEMS) ? THR_MAX : staged_table[idx + 1];
      val = (hi >= lo) ? THR_W'(lo + $urandom_range(0, hi - lo)) : lo;
      queue_item(OP_LOAD, IDX_W'(idx), val);
   endtask

   initial begin
      logic [COUNT_W-1:0] count_value;
      int                 n;
      int                 r;
      for (int i = 1; i <= ZS_MAX_ITEMS; i++) thresholds[i] = '0;
      for (int i = 0; i <= ZS_MAX_ITEMS; i++) staged_table[i] = '0;
      for (int i = 0; i <= ZS_MAX_ITEMS; i++) staged_written[i] = (i == 0);
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // single value: threshold of zero is never reached, full scale always is
      settle_block();
      write_item_count('0);
      queue_item(OP_LOAD, 13'd1, '0);
      queue_draw();
      queue_item(OP_LOAD, 13'd1, THR_MAX);
      queue_draw();
      // out-of-range loads must leave the table alone
      queue_item(OP_LOAD, 13'd0, '0);
      queue_item(OP_LOAD, '1, '0);
      queue_item(OP_LOAD, 13'(ZS_MAX_ITEMS + 1), '0);
      queue_draw();
      settle_block();
      write_item_count(13'd1);
      queue_draw();
      settle_block();

      // two values: ordered, unordered, and nothing reached
      write_item_count(13'd2);
      queue_item(OP_LOAD, 13'd2, THR_MAX);
      queue_item(OP_LOAD, 13'd1, 31'h4000_0000);
      repeat (3) queue_draw();
      queue_item(OP_LOAD, 13'd1, THR_MAX);
      queue_item(OP_LOAD, 13'd2, '0);
      repeat (2) queue_draw();
      queue_item(OP_LOAD, 13'd1, '0);
      queue_item(OP_LOAD, 13'd2, '0);
      queue_draw();
      settle_block();

      // full count back to back, then draws while the result side holds off
      write_item_count('1);
      idle_mode = 0;
      repeat (8) queue_draw();
      settle_block();
      idle_mode = 1;
      long_holds_asked++;
      repeat (30) queue_draw();
      settle_block();
      write_item_count(13'(ZS_MAX_ITEMS));
      repeat (8) queue_draw();
      settle_block();
      write_item_count(13'(ZS_MAX_ITEMS + 1));
      repeat (4) queue_draw();

      while (queued_items < TOTAL_ITEMS) begin
         r = $urandom_range(0, 99);
         if (r < 45) count_value = 13'($urandom_range(1, 16));
         else if (r < 60) count_value = 13'($urandom_range(17, 300));
         else if (r < 70) count_value = 13'(ZS_MAX_ITEMS);
         else if (r < 78) count_value = '0;
         else if (r < 86) count_value = 13'($urandom_range(ZS_MAX_ITEMS + 1, 8191));
         else count_value = 13'($urandom_range(1, ZS_MAX_ITEMS));
         settle_block();
         write_item_count(count_value);
         n = search_count;
         idle_mode = ($urandom_range(0, 3) != 0);
         if (n <= 32 && $urandom_range(0, 9) < 7) load_cdf(n);
         else repeat ($urandom_range(1, 6)) patch_entry(n);
         repeat ($urandom_range(4, 16)) begin
            r = $urandom_range(0, 99);
            if (r < 80) begin
               queue_draw();
            end else if (r < 90) begin
               queue_item(OP_LOAD, IDX_W'($urandom_range(1, ZS_MAX_ITEMS)),
                          THR_W'($urandom));
            end else if (r < 95) begin
               if ($urandom_range(0, 1) == 0) queue_item(OP_LOAD, '0, THR_W'($urandom));
               else queue_item(OP_LOAD, IDX_W'($urandom_range(ZS_MAX_ITEMS + 1, 8191)),
                               THR_W'($urandom));
            end else begin
               patch_entry(n);
            end
         end
      end

      settle_block();
      if (mismatches == 0 && expected_samples.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

### filelist.f
sv/zs_pkg.sv
sv/zs_front.sv
sv/zs_cmd_fifo.sv
sv/zs_back.sv
sv/zipf_sampler_top.sv
bench/tb_top.sv
